[hw/rtl/mspts_pkg.sv]
// Shared types and constants for the periodic tick scheduler.
package mspts_pkg;

    localparam int unsigned SLOT_COUNT_DEF = 8;
    localparam int unsigned PER_W = 31;
    localparam int unsigned HID_W = 16;
    localparam int unsigned RES_SLOT_W = 6;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SET      = 3'd1,
        CMD_ADD      = 3'd2,
        CMD_CLR_SLOT = 3'd3,
        CMD_CLR_HID  = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_FIRED = 2'd0,
        KIND_REPLY = 2'd1,
        KIND_IDLE  = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_READ  = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    typedef struct packed {
        logic [PER_W-1:0] period;
        logic [PER_W-1:0] count;
        logic [HID_W-1:0] hid;
    } slot_entry_t;

    typedef struct packed {
        kind_t                 kind;
        logic [RES_SLOT_W-1:0] slot;
        logic [HID_W-1:0]      hid;
        logic                  status;
    } result_t;

endpackage

[hw/rtl/multi_slot_periodic_tick_scheduler.sv]
// Periodic timer slot table with a one-slot-at-a-time sweep sequencer.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------------
//  command  | cmd_valid / cmd_stall | command, slot, period_ms, handler_id
//  result   | res_valid / res_stall | kind, slot_res, handler_id_res, status, last
//
// Set and clear slot answer without a sweep. Tick, add and clear by handler
// sweep the slot memory one slot at a time (registered read, then evaluate);
// add and clear by handler stop at the first hit.
// Reset clears the active bits at once, so no clearing pass is needed.
// A held res_stall holds the flush, and the sweep when a second fired item needs
// the output register; the block is ready again once its last item is registered.
module multi_slot_periodic_tick_scheduler #(
    parameter int unsigned SLOT_COUNT = mspts_pkg::SLOT_COUNT_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cmd_valid,
    output logic                               cmd_stall,
    input  logic [2:0]                         command,
    input  logic [7:0]                         slot,
    input  logic signed [31:0]                 period_ms,
    input  logic [15:0]                        handler_id,
    output logic                               res_valid,
    input  logic                               res_stall,
    output logic [1:0]                         kind,
    output logic [mspts_pkg::RES_SLOT_W-1:0]   slot_res,
    output logic [mspts_pkg::HID_W-1:0]        handler_id_res,
    output logic                               status,
    output logic                               last
);

    localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(SLOT_COUNT - 1);

    mspts_pkg::state_t      state_reg, state_next;
    mspts_pkg::cmd_t        cmd_reg, cmd_next;
    logic [mspts_pkg::PER_W-1:0] per_reg, per_next;
    logic [mspts_pkg::HID_W-1:0] hid_reg, hid_next;
    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [SLOT_COUNT-1:0]  active_reg, active_next;
    mspts_pkg::result_t     pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;
    mspts_pkg::result_t     out_reg, out_next;
    logic                   out_last_reg, out_last_next;
    logic                   out_valid_reg, out_valid_next;

    mspts_pkg::slot_entry_t mem [SLOT_COUNT];
    mspts_pkg::slot_entry_t rd_reg;
    logic                   wr_en;
    logic [SLOT_W-1:0]      wr_addr;
    mspts_pkg::slot_entry_t wr_data;

    logic                   out_free;
    logic                   pgood;
    logic                   in_range;
    logic                   fire;
    logic [mspts_pkg::PER_W-1:0] dec_in;
    logic [mspts_pkg::PER_W-1:0] new_count;
    mspts_pkg::result_t     err_reply;

    assign cmd_stall      = (state_reg != mspts_pkg::ST_IDLE);
    assign res_valid      = out_valid_reg;
    assign kind           = out_reg.kind;
    assign slot_res       = out_reg.slot;
    assign handler_id_res = out_reg.hid;
    assign status         = out_reg.status;
    assign last           = out_last_reg;

    assign out_free = !out_valid_reg || !res_stall;
    assign pgood    = !period_ms[31] && (period_ms != 32'sd0);
    assign in_range = {1'b0, slot} < 9'(SLOT_COUNT);

    assign err_reply = '{kind: mspts_pkg::KIND_REPLY, slot: '0, hid: '0, status: 1'b1};

    // A countdown at or below one reloads; reloading from one gives the period
    // itself, so a single decrementer covers both the plain and the reload case.
    assign fire      = (rd_reg.count <= 31'd1);
    assign dec_in    = fire ? rd_reg.period : rd_reg.count;
    assign new_count = (fire && rd_reg.count[0]) ? rd_reg.period : dec_in - 31'd1;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        per_next        = per_reg;
        hid_next        = hid_reg;
        idx_next        = idx_reg;
        active_next     = active_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && res_stall;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = '{period: per_reg, count: per_reg, hid: hid_reg};

        case (state_reg)
            mspts_pkg::ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next        = mspts_pkg::cmd_t'(command);
                    per_next        = period_ms[30:0];
                    hid_next        = handler_id;
                    idx_next        = '0;
                    pend_next       = err_reply;
                    pend_valid_next = 1'b1;
                    state_next      = mspts_pkg::ST_FLUSH;
                    case (mspts_pkg::cmd_t'(command))
                        mspts_pkg::CMD_TICK:
                        begin
                            pend_valid_next = 1'b0;
                            state_next      = mspts_pkg::ST_READ;
                        end
                        mspts_pkg::CMD_SET:
                        begin
                            if (pgood && in_range)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = slot[SLOT_W-1:0];
                                wr_data = '{period: period_ms[30:0], count: period_ms[30:0],
                                            hid: handler_id};
                                active_next[slot[SLOT_W-1:0]] = 1'b1;
                                pend_next = '{kind: mspts_pkg::KIND_REPLY,
                                              slot: mspts_pkg::RES_SLOT_W'(slot[SLOT_W-1:0]),
                                              hid: '0, status: 1'b0};
                            end
                        end
                        mspts_pkg::CMD_ADD:
                        begin
                            if (pgood)
                            begin
                                state_next = mspts_pkg::ST_READ;
                            end
                        end
                        mspts_pkg::CMD_CLR_SLOT:
                        begin
                            if (in_range)
                            begin
                                active_next[slot[SLOT_W-1:0]] = 1'b0;
                                pend_next = '{kind: mspts_pkg::KIND_REPLY,
                                              slot: mspts_pkg::RES_SLOT_W'(slot[SLOT_W-1:0]),
                                              hid: '0, status: 1'b0};
                            end
                        end
                        mspts_pkg::CMD_CLR_HID:
                        begin
                            state_next = mspts_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = mspts_pkg::ST_FLUSH;
                        end
                    endcase
                end
            end
            mspts_pkg::ST_READ:
            begin
                state_next = mspts_pkg::ST_EVAL;
            end
            mspts_pkg::ST_EVAL:
            begin
                logic advance;
                logic found;
                advance = 1'b1;
                found   = 1'b0;
                case (cmd_reg)
                    mspts_pkg::CMD_TICK:
                    begin
                        if (active_reg[idx_reg])
                        begin
                            if (fire && pend_valid_reg && !out_free)
                            begin
                                advance = 1'b0;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_data = '{period: rd_reg.period, count: new_count,
                                            hid: rd_reg.hid};
                                if (fire)
                                begin
                                    // The previous hit is known not to be last now.
                                    if (pend_valid_reg)
                                    begin
                                        out_next       = pend_reg;
                                        out_last_next  = 1'b0;
                                        out_valid_next = 1'b1;
                                    end
                                    pend_next = '{kind: mspts_pkg::KIND_FIRED,
                                                  slot: mspts_pkg::RES_SLOT_W'(idx_reg),
                                                  hid: rd_reg.hid, status: 1'b0};
                                    pend_valid_next = 1'b1;
                                end
                            end
                        end
                    end
                    mspts_pkg::CMD_ADD:
                    begin
                        if (!active_reg[idx_reg])
                        begin
                            wr_en                = 1'b1;
                            active_next[idx_reg] = 1'b1;
                            found                = 1'b1;
                        end
                    end
                    mspts_pkg::CMD_CLR_HID:
                    begin
                        if (active_reg[idx_reg] && (rd_reg.hid == hid_reg))
                        begin
                            active_next[idx_reg] = 1'b0;
                            found                = 1'b1;
                        end
                    end
                    default:
                    begin
                        found = 1'b0;
                    end
                endcase
                if (found)
                begin
                    pend_next = '{kind: mspts_pkg::KIND_REPLY,
                                  slot: mspts_pkg::RES_SLOT_W'(idx_reg),
                                  hid: '0, status: 1'b0};
                    state_next = mspts_pkg::ST_FLUSH;
                end
                else if (advance)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = mspts_pkg::ST_FLUSH;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = mspts_pkg::ST_READ;
                    end
                end
            end
            mspts_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_next = pend_reg;
                    end
                    else
                    begin
                        out_next = '{kind: mspts_pkg::KIND_IDLE, slot: '0, hid: '0,
                                     status: 1'b0};
                    end
                    out_last_next   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = mspts_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mspts_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mspts_pkg::ST_IDLE;
            cmd_reg        <= mspts_pkg::CMD_TICK;
            per_reg        <= '0;
            hid_reg        <= '0;
            idx_reg        <= '0;
            active_reg     <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_reg        <= '0;
            out_last_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            per_reg        <= per_next;
            hid_reg        <= hid_next;
            idx_reg        <= idx_next;
            active_reg     <= active_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            out_reg        <= out_next;
            out_last_reg   <= out_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Slot memory: one write port, one registered read port at the sweep index.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[idx_reg];
    end

    // Only fired items can be followed by more items of the same input.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !last |-> kind == mspts_pkg::KIND_FIRED)
        else $error("non-final item that is not a fired slot");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != mspts_pkg::KIND_FIRED |-> last)
        else $error("reply or idle item without last");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && kind != mspts_pkg::KIND_REPLY |-> !status)
        else $error("error status outside a command reply");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second item accepted before the first finished");

endmodule

[verif/multi_slot_periodic_tick_scheduler_tb.sv]
// Self-checking testbench for the periodic tick scheduler: directed table, then random phases.
module multi_slot_periodic_tick_scheduler_tb;

    localparam int SLOT_N = mspts_pkg::SLOT_COUNT_DEF;
    localparam logic [2:0] CMD_UNDEF_5 = 3'd5;
    localparam logic [2:0] CMD_UNDEF_7 = 3'd7;
    localparam int RANDOM_PER_PHASE = 112;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 2 * SLOT_N + 8;
    localparam int REPORT_MAX = 10;
    localparam int SEND_IDLE [4] = '{0, 68, 0, 22};
    localparam int RECV_STALL [4] = '{0, 0, 68, 22};

    typedef struct packed {
        mspts_pkg::kind_t                 kind;
        logic [mspts_pkg::RES_SLOT_W-1:0] slot;
        logic [mspts_pkg::HID_W-1:0]      hid;
        logic                             status;
        logic                             last;
    } sched_res_t;

    // One directed item; typed rows carry the single reply or idle result by hand.
    typedef struct packed {
        logic [2:0]                       cmd;
        logic [7:0]                       slot;
        logic [31:0]                      period;
        logic [15:0]                      hid;
        logic                             typed;
        mspts_pkg::kind_t                 kind;
        logic [mspts_pkg::RES_SLOT_W-1:0] rslot;
        logic                             status;
    } stim_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cmd_valid;
    logic                             cmd_stall;
    logic [2:0]                       command;
    logic [7:0]                       slot;
    logic signed [31:0]               period_ms;
    logic [15:0]                      handler_id;
    logic                             res_valid;
    logic                             res_stall;
    logic [1:0]                       kind;
    logic [mspts_pkg::RES_SLOT_W-1:0] slot_res;
    logic [mspts_pkg::HID_W-1:0]      handler_id_res;
    logic                             status;
    logic                             last;

    // Shadow copy of the slot table.
    logic [mspts_pkg::PER_W-1:0] period_tab [SLOT_N];
    logic [mspts_pkg::PER_W-1:0] count_tab [SLOT_N];
    logic [mspts_pkg::HID_W-1:0] hid_tab [SLOT_N];

    sched_res_t step_out [$];
    sched_res_t due_results [$];

    int send_idle_pct;
    int stall_pct;
    int mismatch_count = 0;
    int items_sent;
    int results_seen = 0;
    int fired_seen = 0;
    int error_replies = 0;
    int burst = 0;
    int burst_max = 0;
    int quiet_cycles = 0;

    stim_row_t dir_rows [25] = '{
        '{mspts_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 1'b1, mspts_pkg::KIND_IDLE, 6'd0, 1'b0},
        '{mspts_pkg::CMD_CLR_HID, 8'd0, 32'd0, 16'd0, 1'b1, mspts_pkg::KIND_REPLY, 6'd0, 1'b1},
        '{mspts_pkg::CMD_SET, 8'd8, 32'd5, 16'd1, 1'b1, mspts_pkg::KIND_REPLY, 6'd0, 1'b1},
        '{mspts_pkg::CMD_SET, 8'd0, 32'd0, 16'd1, 1'b1, mspts_pkg::KIND_REPLY, 6'd0, 1'b1},
        '{mspts_pkg::CMD_SET, 8'd0, 32'h8000_0000, 16'd1, 1'b1, mspts_pkg::KIND_REPLY,
          6'd0, 1'b1},
        '{mspts_pkg::CMD_ADD, 8'd0, 32'hFFFF_FFFF, 16'd1, 1'b1, mspts_pkg::KIND_REPLY,
          6'd0, 1'b1},
        '{CMD_UNDEF_5, 8'hFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, mspts_pkg::KIND_REPLY, 6'd0, 1'b1},
        '{CMD_UNDEF_7, 8'd0, 32'd1, 16'd0, 1'b1, mspts_pkg::KIND_REPLY, 6'd0, 1'b1},
        '{mspts_pkg::CMD_SET, 8'd0, 32'd1, 16'hFFFF, 1'b1, mspts_pkg::KIND_REPLY, 6'd0, 1'b0},
        '{mspts_pkg::CMD_SET, 8'd7, 32'h7FFF_FFFF, 16'd0, 1'b1, mspts_pkg::KIND_REPLY,
          6'd7, 1'b0},
        '{mspts_pkg::CMD_ADD, 8'd0, 32'd1, 16'h0101, 1'b1, mspts_pkg::KIND_REPLY, 6'd1, 1'b0},
        '{mspts_pkg::CMD_ADD, 8'd0, 32'd2, 16'h0202, 1'b1, mspts_pkg::KIND_REPLY, 6'd2, 1'b0},
        '{mspts_pkg::CMD_ADD, 8'd0, 32'd3, 16'h0303, 1'b1, mspts_pkg::KIND_REPLY, 6'd3, 1'b0},
        '{mspts_pkg::CMD_ADD, 8'd0, 32'd1, 16'h0404, 1'b1, mspts_pkg::KIND_REPLY, 6'd4, 1'b0},
        '{mspts_pkg::CMD_ADD, 8'd0, 32'd2, 16'h0505, 1'b1, mspts_pkg::KIND_REPLY, 6'd5, 1'b0},
        '{mspts_pkg::CMD_ADD, 8'd0, 32'd1, 16'h0606, 1'b1, mspts_pkg::KIND_REPLY, 6'd6, 1'b0},
        '{mspts_pkg::CMD_ADD, 8'd0, 32'd4, 16'h0707, 1'b1, mspts_pkg::KIND_REPLY, 6'd0, 1'b1},
        '{mspts_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 1'b0, mspts_pkg::KIND_IDLE, 6'd0, 1'b0},
        '{mspts_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 1'b0, mspts_pkg::KIND_IDLE, 6'd0, 1'b0},
        '{mspts_pkg::CMD_SET, 8'd0, 32'd3, 16'h5555, 1'b1, mspts_pkg::KIND_REPLY, 6'd0, 1'b0},
        '{mspts_pkg::CMD_CLR_SLOT, 8'd3, 32'd0, 16'd0, 1'b1, mspts_pkg::KIND_REPLY,
          6'd3, 1'b0},
        '{mspts_pkg::CMD_CLR_SLOT, 8'd3, 32'd0, 16'd0, 1'b1, mspts_pkg::KIND_REPLY,
          6'd3, 1'b0},
        '{mspts_pkg::CMD_CLR_SLOT, 8'hFF, 32'd0, 16'd0, 1'b1, mspts_pkg::KIND_REPLY,
          6'd0, 1'b1},
        '{mspts_pkg::CMD_CLR_HID, 8'd0, 32'd0, 16'h0202, 1'b1, mspts_pkg::KIND_REPLY,
          6'd2, 1'b0},
        '{mspts_pkg::CMD_TICK, 8'd0, 32'd0, 16'd0, 1'b0, mspts_pkg::KIND_IDLE, 6'd0, 1'b0}
    };

    multi_slot_periodic_tick_scheduler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_valid      (cmd_valid),
        .cmd_stall      (cmd_stall),
        .command        (command),
        .slot           (slot),
        .period_ms      (period_ms),
        .handler_id     (handler_id),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .kind           (kind),
        .slot_res       (slot_res),
        .handler_id_res (handler_id_res),
        .status         (status),
        .last           (last)
    );

    function automatic sched_res_t mk_res(mspts_pkg::kind_t k, int s,
                                          logic [mspts_pkg::HID_W-1:0] h,
                                          logic st, logic l);
        sched_res_t r;
        r.kind = k;
        r.slot = s[mspts_pkg::RES_SLOT_W-1:0];
        r.hid = h;
        r.status = st;
        r.last = l;
        return r;
    endfunction

    // Applies one command to the shadow table and leaves its results in step_out.
    function automatic void schedule_step(logic [2:0] c, logic [7:0] s, logic [31:0] p,
                                          logic [15:0] h);
        logic                        pgood;
        logic [mspts_pkg::PER_W-1:0] per;
        logic [mspts_pkg::PER_W-1:0] nc;
        sched_res_t                  r;
        int                          hit;
        int                          i;
        pgood = !p[31] && (p != 32'd0);
        per = p[mspts_pkg::PER_W-1:0];
        hit = -1;
        step_out.delete();
        case (c)
            mspts_pkg::CMD_TICK:
            begin
                for (i = 0; i < SLOT_N; i++)
                begin
                    if (period_tab[i] != '0)
                    begin
                        nc = count_tab[i] - 1'b1;
                        if (count_tab[i] <= 1)
                        begin
                            nc = nc + period_tab[i];
                            step_out.push_back(mk_res(mspts_pkg::KIND_FIRED, i, hid_tab[i],
                                                      1'b0, 1'b0));
                        end
                        count_tab[i] = nc;
                    end
                end
                if (step_out.size() == 0)
                    step_out.push_back(mk_res(mspts_pkg::KIND_IDLE, 0, '0, 1'b0, 1'b1));
                else
                begin
                    r = step_out.pop_back();
                    r.last = 1'b1;
                    step_out.push_back(r);
                end
            end
            mspts_pkg::CMD_SET:
            begin
                if (pgood && s < SLOT_N)
                    hit = s;
            end
            mspts_pkg::CMD_ADD:
            begin
                for (i = 0; i < SLOT_N; i++)
                begin
                    if (pgood && hit < 0 && period_tab[i] == '0)
                        hit = i;
                end
            end
            mspts_pkg::CMD_CLR_SLOT:
            begin
                if (s < SLOT_N)
                begin
                    hit = s;
                    period_tab[hit] = '0;
                end
            end
            mspts_pkg::CMD_CLR_HID:
            begin
                for (i = 0; i < SLOT_N; i++)
                begin
                    if (hit < 0 && period_tab[i] != '0 && hid_tab[i] == h)
                        hit = i;
                end
                if (hit >= 0)
                    period_tab[hit] = '0;
            end
            default:
            begin
                hit = -1;
            end
        endcase
        // Set and add both load the chosen slot and restart its countdown.
        if (hit >= 0 && (c == mspts_pkg::CMD_SET || c == mspts_pkg::CMD_ADD))
        begin
            period_tab[hit] = per;
            count_tab[hit] = per;
            hid_tab[hit] = h;
        end
        if (c != mspts_pkg::CMD_TICK)
        begin
            if (hit >= 0)
                step_out.push_back(mk_res(mspts_pkg::KIND_REPLY, hit, '0, 1'b0, 1'b1));
            else
                step_out.push_back(mk_res(mspts_pkg::KIND_REPLY, 0, '0, 1'b1, 1'b1));
        end
    endfunction

    // Entered at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_item(input logic [2:0] c, input logic [7:0] s, input logic [31:0] p,
                             input logic [15:0] h, input logic typed, input sched_res_t typed_res);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid <= 1'b1;
        command <= c;
        slot <= s;
        period_ms <= p;
        handler_id <= h;
        do
            @(posedge clk);
        while (cmd_stall !== 1'b0);
        schedule_step(c, s, p, h);
        if (typed)
            due_results.push_back(typed_res);
        else
            foreach (step_out[k])
                due_results.push_back(step_out[k]);
        items_sent++;
        @(negedge clk);
    endtask

    // Mostly small periods and a small pool of handlers so that slots fire and matches hit.
    task automatic pick_random(output logic [2:0] c, output logic [7:0] s,
                               output logic [31:0] p, output logic [15:0] h);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            c = mspts_pkg::CMD_TICK;
        else if (roll < 59)
            c = mspts_pkg::CMD_SET;
        else if (roll < 75)
            c = mspts_pkg::CMD_ADD;
        else if (roll < 85)
            c = mspts_pkg::CMD_CLR_SLOT;
        else if (roll < 97)
            c = mspts_pkg::CMD_CLR_HID;
        else
            c = 3'($urandom_range(CMD_UNDEF_5, CMD_UNDEF_7));
        if ($urandom_range(0, 99) < 85)
            s = 8'($urandom_range(0, SLOT_N - 1));
        else
            s = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 75)
            p = 32'($urandom_range(1, 4));
        else if (roll < 85)
            p = 32'($urandom_range(5, 40));
        else if (roll < 93)
            p = $urandom();
        else if (roll < 96)
            p = 32'd0;
        else
            p = $urandom() | 32'h8000_0000;
        if ($urandom_range(0, 99) < 85)
            h = 16'($urandom_range(0, 7));
        else
            h = 16'($urandom_range(0, 65535));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            res_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge clk)
    begin
        sched_res_t want;
        if (rst_n === 1'b1 && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            results_seen++;
            if (due_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("unexpected result: kind %0d slot %0d hid %h status %0b last %0b",
                             kind, slot_res, handler_id_res, status, last);
            end
            else
            begin
                want = due_results.pop_front();
                if (kind !== want.kind || slot_res !== want.slot || handler_id_res !== want.hid
                    || status !== want.status || last !== want.last)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                    begin
                        $display("mismatch: expected kind %0d slot %0d hid %h status %0b last %0b",
                                 want.kind, want.slot, want.hid, want.status, want.last);
                        $display("          got kind %0d slot %0d hid %h status %0b last %0b",
                                 kind, slot_res, handler_id_res, status, last);
                    end
                end
                if (want.kind == mspts_pkg::KIND_FIRED)
                begin
                    fired_seen++;
                    burst++;
                end
                if (want.status)
                    error_replies++;
                if (want.last)
                begin
                    if (burst > burst_max)
                        burst_max = burst;
                    burst = 0;
                end
            end
        end
    end

    // Ends the run when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
            (res_valid === 1'b1 && res_stall === 1'b0))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles, %0d results outstanding",
                     QUIET_LIMIT, due_results.size());
            $display("multi_slot_periodic_tick_scheduler_tb NOT OK");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [2:0]  c;
        logic [7:0]  s;
        logic [31:0] p;
        logic [15:0] h;
        int          ph;
        rst_n = 1'b0;
        cmd_valid = 1'b0;
        command = '0;
        slot = '0;
        period_ms = '0;
        handler_id = '0;
        send_idle_pct = 0;
        stall_pct = 0;
        items_sent = 0;
        for (int i = 0; i < SLOT_N; i++)
        begin
            period_tab[i] = '0;
            count_tab[i] = '0;
            hid_tab[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[r])
            send_item(dir_rows[r].cmd, dir_rows[r].slot, dir_rows[r].period, dir_rows[r].hid,
                      dir_rows[r].typed,
                      mk_res(dir_rows[r].kind, dir_rows[r].rslot, '0, dir_rows[r].status, 1'b1));

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = SEND_IDLE[ph];
            stall_pct = RECV_STALL[ph];
            repeat (RANDOM_PER_PHASE)
            begin
                pick_random(c, s, p, h);
                send_item(c, s, p, h, 1'b0, '0);
            end
        end
        cmd_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d commands sent under four idle/stall mixes, %0d results checked",
                 items_sent, results_seen);
        $display("%0d slot firings (at most %0d on one tick), %0d error replies, %0d mismatches",
                 fired_seen, burst_max, error_replies, mismatch_count);
        if (mismatch_count == 0)
            $display("multi_slot_periodic_tick_scheduler_tb OK");
        else
            $display("multi_slot_periodic_tick_scheduler_tb NOT OK");
        $finish;
    end

endmodule
